>>> design/permutation_rank_unrank_macros.svh
// assertion macros shared by the permutation rank/unrank design files
`ifndef PERMUTATION_RANK_UNRANK_MACROS_SVH
`define PERMUTATION_RANK_UNRANK_MACROS_SVH

`ifndef ASSERT_OFF

// same-cycle implication, disabled while in reset
`define PRU_ASSERT_IMP(lbl, clk_s, rstn_s, ante, cons) \
  lbl: assert property (@(posedge clk_s) disable iff (!rstn_s) (ante) |-> (cons)) \
    else $error("pru assertion failed");

// next-cycle implication, disabled while in reset
`define PRU_ASSERT_NXT(lbl, clk_s, rstn_s, ante, cons) \
  lbl: assert property (@(posedge clk_s) disable iff (!rstn_s) (ante) |=> (cons)) \
    else $error("pru assertion failed");

`else

`define PRU_ASSERT_IMP(lbl, clk_s, rstn_s, ante, cons)
`define PRU_ASSERT_NXT(lbl, clk_s, rstn_s, ante, cons)

`endif

`endif

>>> design/pru_pkg.sv
// types and helper functions for the permutation rank/unrank pipeline
`default_nettype none

package pru_pkg;

  // number of element positions carried on the ports
  localparam int NUM_POS = 8;

  // one 3-bit element per position, position 0 in the low bits
  typedef logic [NUM_POS-1:0][2:0] pos_vec_t;

  // input transaction
  typedef struct packed {
    logic        kind;
    logic [15:0] rank_in;
    logic [2:0]  in_pos0;
    logic [2:0]  in_pos1;
    logic [2:0]  in_pos2;
    logic [2:0]  in_pos3;
    logic [2:0]  in_pos4;
    logic [2:0]  in_pos5;
    logic [2:0]  in_pos6;
    logic [2:0]  in_pos7;
  } in_t;

  // result transaction
  typedef struct packed {
    logic [15:0] rank_out;
    logic        bad_index;
    logic [2:0]  out_pos0;
    logic [2:0]  out_pos1;
    logic [2:0]  out_pos2;
    logic [2:0]  out_pos3;
    logic [2:0]  out_pos4;
    logic [2:0]  out_pos5;
    logic [2:0]  out_pos6;
    logic [2:0]  out_pos7;
  } out_t;

  // contents of one pipeline stage
  typedef struct packed {
    logic        kind;
    logic        bad;
    logic [15:0] rem;
    pos_vec_t    pool;
    pos_vec_t    res;
    pos_vec_t    cnt;
    logic [15:0] psum_a;
    logic [15:0] psum_b;
  } pipe_t;

  // factorial of a small constant, 8! still fits in 16 bits
  function automatic logic [15:0] fact16(input int n);
    int f;
    f = 1;
    for (int k = 2; k <= n; k++) begin
      f = f * k;
    end
    return f[15:0];
  endfunction

  // quotient of rem by the constant f, capped at NUM_POS-1, counted by comparing against multiples
  function automatic logic [2:0] lehmer_digit(input logic [15:0] rem, input logic [15:0] f);
    logic [2:0]  q;
    logic [18:0] kf;
    q = 3'd0;
    for (int k = 1; k < NUM_POS; k++) begin
      kf = 19'(k) * {3'b000, f};
      if ({3'b000, rem} >= kf) begin
        q = 3'(k);
      end
    end
    return q;
  endfunction

  // take the pool entry for one position and close the gap it leaves
  function automatic pipe_t unrank_step(input pipe_t p, input int pos, input int n);
    pipe_t       t;
    logic [2:0]  q;
    logic [15:0] f;
    logic [18:0] prod;
    t = p;
    if (pos < n) begin
      f = fact16(n - 1 - pos);
      q = lehmer_digit(p.rem, f);
      t.res[pos] = p.pool[q];
      for (int j = 0; j < NUM_POS; j++) begin
        if (3'(j) < q) begin
          t.pool[j] = p.pool[j];
        end else if (j < NUM_POS - 1) begin
          t.pool[j] = p.pool[j+1];
        end else begin
          t.pool[j] = p.pool[j];
        end
      end
      prod = {16'h0000, q} * {3'b000, f};
      t.rem = p.rem - prod[15:0];
    end
    return t;
  endfunction

endpackage

`default_nettype wire

>>> design/permutation_rank_unrank.sv
// top level: four-stage pipelined lehmer code rank / unrank unit
//
//  channel  direction  payload           handshake
//  in_      input      pru_pkg::in_t     in_valid, in_stall
//  out_     output     pru_pkg::out_t    out_valid, out_stall
//
// one transaction per cycle sustained while out_stall is low; an accepted transaction
// passes through stages 1 to 4 in order, and out_valid rises when it reaches stage 4.
// the pipeline is four register stages, the last one the output
// register. stage 1 counts smaller later elements and takes unrank position 0,
// stage 2 weights the counts and takes positions 1-2, stage 3 sums and takes
// positions 3-5, stage 4 takes positions 6-7 and formats the result.
// reset clears the stage valid bits only. each stage advances when it is empty
// or the one after it advances, so bubbles close up under out_stall.
`default_nettype none
`include "permutation_rank_unrank_macros.svh"

module permutation_rank_unrank #(
  parameter int PERM_SIZE = 8
) (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          in_valid,
  output logic               in_stall,
  input  wire pru_pkg::in_t  in_data,
  output logic               out_valid,
  input  wire logic          out_stall,
  output pru_pkg::out_t      out_data
);

  localparam logic [15:0] FACT_N = pru_pkg::fact16(PERM_SIZE);

  pru_pkg::pipe_t   s1_r, s1_nxt;
  pru_pkg::pipe_t   s2_r, s2_nxt;
  pru_pkg::pipe_t   s3_r, s3_nxt;
  pru_pkg::pipe_t   s3_step;
  pru_pkg::out_t    s4_r, s4_nxt;
  logic             s1_valid_r, s2_valid_r, s3_valid_r, s4_valid_r;
  logic             adv1, adv2, adv3, adv4;
  pru_pkg::pos_vec_t in_elem;
  logic             out_any;
  logic             pipe_full;

  // stage advance chain
  assign adv4 = !s4_valid_r || !out_stall;
  assign adv3 = !s3_valid_r || adv4;
  assign adv2 = !s2_valid_r || adv3;
  assign adv1 = !s1_valid_r || adv2;
  assign in_stall = !adv1;

  assign in_elem = {in_data.in_pos7, in_data.in_pos6, in_data.in_pos5, in_data.in_pos4,
                    in_data.in_pos3, in_data.in_pos2, in_data.in_pos1, in_data.in_pos0};

  // stage 1: inversion counts, range check, unrank position 0
  always_comb begin
    s1_nxt        = '0;
    s1_nxt.kind   = in_data.kind;
    s1_nxt.bad    = in_data.kind && (in_data.rank_in >= FACT_N);
    s1_nxt.rem    = in_data.rank_in;
    for (int j = 0; j < pru_pkg::NUM_POS; j++) begin
      s1_nxt.pool[j] = 3'(j);
    end
    for (int i = 0; i < pru_pkg::NUM_POS; i++) begin
      for (int j = i + 1; j < pru_pkg::NUM_POS; j++) begin
        if ((j < PERM_SIZE) && (in_elem[i] > in_elem[j])) begin
          s1_nxt.cnt[i] = s1_nxt.cnt[i] + 3'd1;
        end
      end
    end
    s1_nxt = pru_pkg::unrank_step(s1_nxt, 0, PERM_SIZE);
  end

  // stage 2: weighted counts in two halves, unrank positions 1 and 2
  always_comb begin
    s2_nxt        = pru_pkg::unrank_step(pru_pkg::unrank_step(s1_r, 1, PERM_SIZE), 2, PERM_SIZE);
    s2_nxt.psum_a = '0;
    s2_nxt.psum_b = '0;
    for (int i = 0; i < pru_pkg::NUM_POS / 2; i++) begin
      if (i < PERM_SIZE) begin
        s2_nxt.psum_a = s2_nxt.psum_a
                      + 16'({13'h0000, s1_r.cnt[i]} * pru_pkg::fact16(PERM_SIZE - 1 - i));
      end
    end
    for (int i = pru_pkg::NUM_POS / 2; i < pru_pkg::NUM_POS; i++) begin
      if (i < PERM_SIZE) begin
        s2_nxt.psum_b = s2_nxt.psum_b
                      + 16'({13'h0000, s1_r.cnt[i]} * pru_pkg::fact16(PERM_SIZE - 1 - i));
      end
    end
  end

  // stage 3: final rank sum, unrank positions 3 to 5
  always_comb begin
    s3_step       = pru_pkg::unrank_step(pru_pkg::unrank_step(s2_r, 3, PERM_SIZE), 4, PERM_SIZE);
    s3_nxt        = pru_pkg::unrank_step(s3_step, 5, PERM_SIZE);
    s3_nxt.psum_a = s2_r.psum_a + s2_r.psum_b;
  end

  // stage 4: unrank positions 6 and 7, mask fields by mode
  always_comb begin
    pru_pkg::pipe_t t;
    t = pru_pkg::unrank_step(pru_pkg::unrank_step(s3_r, 6, PERM_SIZE), 7, PERM_SIZE);
    if (!t.kind || t.bad) begin
      t.res = '0;
    end
    s4_nxt.rank_out  = t.kind ? 16'h0000 : t.psum_a;
    s4_nxt.bad_index = t.bad;
    s4_nxt.out_pos0  = t.res[0];
    s4_nxt.out_pos1  = t.res[1];
    s4_nxt.out_pos2  = t.res[2];
    s4_nxt.out_pos3  = t.res[3];
    s4_nxt.out_pos4  = t.res[4];
    s4_nxt.out_pos5  = t.res[5];
    s4_nxt.out_pos6  = t.res[6];
    s4_nxt.out_pos7  = t.res[7];
  end

  // stage valid bits
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
      s2_valid_r <= 1'b0;
      s3_valid_r <= 1'b0;
      s4_valid_r <= 1'b0;
    end else begin
      if (adv1) s1_valid_r <= in_valid;
      if (adv2) s2_valid_r <= s1_valid_r;
      if (adv3) s3_valid_r <= s2_valid_r;
      if (adv4) s4_valid_r <= s3_valid_r;
    end
  end

  // stage payloads
  always_ff @(posedge clk) begin
    if (adv1) s1_r <= s1_nxt;
    if (adv2) s2_r <= s2_nxt;
    if (adv3) s3_r <= s3_nxt;
    if (adv4) s4_r <= s4_nxt;
  end

  assign out_valid = s4_valid_r;
  assign out_data  = s4_r;

  // any non-zero rank or element in the output register
  assign out_any = |{s4_r.rank_out, s4_r.out_pos0, s4_r.out_pos1, s4_r.out_pos2,
                     s4_r.out_pos3, s4_r.out_pos4, s4_r.out_pos5, s4_r.out_pos6,
                     s4_r.out_pos7};

  assign pipe_full = s1_valid_r && s2_valid_r && s3_valid_r && s4_valid_r;

  // an out-of-range index gives an all-zero result
  `PRU_ASSERT_IMP(a_bad_zero, clk, rst_n, out_valid && out_data.bad_index, !out_any)
  // a rank never reaches the factorial of the size
  `PRU_ASSERT_IMP(a_rank_range, clk, rst_n, out_valid, out_data.rank_out < FACT_N)
  // input backpressure only when every stage is full and the output is stalled
  `PRU_ASSERT_IMP(a_stall_full, clk, rst_n, in_stall, pipe_full && out_stall)
  // an accepted transaction always lands in stage 1
  `PRU_ASSERT_NXT(a_accept_lands, clk, rst_n, in_valid && !in_stall, s1_valid_r)

endmodule

`default_nettype wire
